FILE: design/nfv5_pkg.sv
// ----------------------------------------------------------------------------
// NetFlow v5 parser package
// Shared types and constants for the NetFlow v5 export packet decoder.
// ----------------------------------------------------------------------------
package nfv5_pkg;

    localparam int HDR_BYTES     = 24;
    localparam int REC_BYTES     = 48;
    localparam int HDR_BITS      = HDR_BYTES * 8;
    localparam int REC_KEEP_BITS = (REC_BYTES - 1) * 8;
    localparam int REC_BITS      = REC_BYTES * 8;

    localparam logic [15:0] NF_VERSION   = 16'd5;
    localparam logic [5:0]  HDR_LAST_IDX = 6'(HDR_BYTES - 1);
    localparam logic [5:0]  REC_LAST_IDX = 6'(REC_BYTES - 1);

    // floor(n / 1e6) is taken as floor((n >> 6) / 15625) by reciprocal.
    localparam int          NSEC_SHIFT   = 6;
    localparam int          RECIP_BITS   = 27;
    localparam int          RECIP_SHIFT  = 40;
    localparam int          Q_BITS       = 13;
    localparam logic [RECIP_BITS-1:0] NSEC_RECIP = 27'd70368744;
    localparam logic [19:0] NSEC_PER_MS  = 20'd1000000;
    localparam logic [9:0]  MS_PER_SEC   = 10'd1000;

    typedef enum logic [2:0] {
        ST_RECORD      = 3'd0,
        ST_RECORD_END  = 3'd1,
        ST_END_OK      = 3'd2,
        ST_SHORT_HDR   = 3'd3,
        ST_BAD_VERSION = 3'd4,
        ST_TRUNCATED   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_RECORDS = 3'b010,
        PH_TRAILER = 3'b100
    } phase_t;

    typedef struct packed {
        logic [31:0] uptime;
        logic [31:0] secs;
        logic [31:0] nsecs;
    } hdr_time_t;

    typedef struct packed {
        status_t            status;
        logic signed [63:0] first_ms;
        logic signed [63:0] last_ms;
        logic [63:0]        addresses;
        logic [31:0]        hop_addr;
        logic [31:0]        ports;
        logic [31:0]        interfaces;
        logic [31:0]        packet_count;
        logic [31:0]        octet_count;
        logic [23:0]        proto_info;
        logic [47:0]        as_and_masks;
        logic [63:0]        header_info;
    } result_t;

endpackage

FILE: design/netflow_v5_record_parser.sv
// ----------------------------------------------------------------------------
// NetFlow v5 record parser
// Decodes a NetFlow v5 export packet, one byte per request, into flow
// records with absolute start and end times, and reports packet status.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Payload
//   in       in_valid, in_stall   data_byte, packet_end
//   out      out_valid, out_stall status, first_ms, last_ms, addresses,
//                                 hop_addr, ports, interfaces, packet_count,
//                                 octet_count, proto_info, as_and_masks,
//                                 header_info
//
// One byte is taken per cycle while in_stall is low; the byte is registered,
// then its result. The base time is worked out in a four-stage pipeline
// after the header, well before the first record can complete.
// Reset clears the packet state; the block is ready in the first cycle after.
// A stalled result holds; further bytes are taken until the input register
// holds a byte whose result has no free slot.
module netflow_v5_record_parser
    import nfv5_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               packet_end,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic signed [63:0] first_ms,
    output logic signed [63:0] last_ms,
    output logic [63:0]        addresses,
    output logic [31:0]        hop_addr,
    output logic [31:0]        ports,
    output logic [31:0]        interfaces,
    output logic [31:0]        packet_count,
    output logic [31:0]        octet_count,
    output logic [23:0]        proto_info,
    output logic [47:0]        as_and_masks,
    output logic [63:0]        header_info
);

    logic               in_valid_reg;
    logic [7:0]         byte_reg;
    logic               end_reg;
    logic               out_valid_reg;
    result_t            out_reg;

    logic               fire;
    logic               res_valid;
    result_t            res;
    hdr_time_t          hdr_time;
    logic signed [63:0] base_ms;

    nfv5_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (fire),
        .data_byte  (byte_reg),
        .packet_end (end_reg),
        .base_ms    (base_ms),
        .hdr_time   (hdr_time),
        .res_valid  (res_valid),
        .res        (res)
    );

    nfv5_base_time u_base_time (
        .clk      (clk),
        .hdr_time (hdr_time),
        .base_ms  (base_ms)
    );

    assign fire     = in_valid_reg && (!res_valid || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire && res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= data_byte;
            end_reg  <= packet_end;
        end
        if (fire && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign first_ms     = out_reg.first_ms;
    assign last_ms      = out_reg.last_ms;
    assign addresses    = out_reg.addresses;
    assign hop_addr     = out_reg.hop_addr;
    assign ports        = out_reg.ports;
    assign interfaces   = out_reg.interfaces;
    assign packet_count = out_reg.packet_count;
    assign octet_count  = out_reg.octet_count;
    assign proto_info   = out_reg.proto_info;
    assign as_and_masks = out_reg.as_and_masks;
    assign header_info  = out_reg.header_info;

endmodule

FILE: design/nfv5_base_time.sv
// ----------------------------------------------------------------------------
// NetFlow v5 base time
// Pipelined computation of the export base time in milliseconds:
// secs*1000 + nsecs/1e6 - uptime, over four register stages.
// ----------------------------------------------------------------------------
module nfv5_base_time
    import nfv5_pkg::*;
(
    input  logic               clk,
    input  hdr_time_t          hdr_time,
    output logic signed [63:0] base_ms
);

    localparam int PROD_BITS = (32 - NSEC_SHIFT) + RECIP_BITS;

    logic [PROD_BITS-1:0] prod_a_next;
    logic [PROD_BITS-1:0] prod_a_reg;
    logic [41:0]          secs_ms_next;
    logic [41:0]          secs_ms_a_reg;
    logic [31:0]          nsecs_a_reg;
    logic [31:0]          uptime_a_reg;

    logic [Q_BITS-1:0]    q0;
    logic [32:0]          qm_next;
    logic [32:0]          qm_reg;
    logic [Q_BITS-1:0]    q0_b_reg;
    logic [41:0]          secs_ms_b_reg;
    logic [31:0]          nsecs_b_reg;
    logic [31:0]          uptime_b_reg;

    logic [32:0]          rem;
    logic [Q_BITS-1:0]    q_fix;
    logic [42:0]          sum_c_next;
    logic [42:0]          sum_c_reg;
    logic [31:0]          uptime_c_reg;

    logic signed [63:0]   base_next;
    logic signed [63:0]   base_reg;

    assign prod_a_next  = {{RECIP_BITS{1'b0}}, hdr_time.nsecs[31:NSEC_SHIFT]}
                        * {{(32 - NSEC_SHIFT){1'b0}}, NSEC_RECIP};
    assign secs_ms_next = {10'd0, hdr_time.secs} * {32'd0, MS_PER_SEC};

    assign q0      = prod_a_reg[RECIP_SHIFT +: Q_BITS];
    assign qm_next = {20'd0, q0} * {13'd0, NSEC_PER_MS};

    assign rem        = {1'b0, nsecs_b_reg} - qm_reg;
    assign q_fix      = q0_b_reg + Q_BITS'(rem >= {13'd0, NSEC_PER_MS});
    assign sum_c_next = {1'b0, secs_ms_b_reg} + {{(43 - Q_BITS){1'b0}}, q_fix};

    assign base_next = $signed({21'd0, sum_c_reg}) - $signed({32'd0, uptime_c_reg});

    always_ff @(posedge clk)
    begin
        prod_a_reg    <= prod_a_next;
        secs_ms_a_reg <= secs_ms_next;
        nsecs_a_reg   <= hdr_time.nsecs;
        uptime_a_reg  <= hdr_time.uptime;

        qm_reg        <= qm_next;
        q0_b_reg      <= q0;
        secs_ms_b_reg <= secs_ms_a_reg;
        nsecs_b_reg   <= nsecs_a_reg;
        uptime_b_reg  <= uptime_a_reg;

        sum_c_reg     <= sum_c_next;
        uptime_c_reg  <= uptime_b_reg;

        base_reg      <= base_next;
    end

    assign base_ms = base_reg;

endmodule

FILE: design/nfv5_decode.sv
// ----------------------------------------------------------------------------
// NetFlow v5 decoder
// Packet phase control, header and record byte capture, and formation of
// the record and status results.
// ----------------------------------------------------------------------------
module nfv5_decode
    import nfv5_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  logic [7:0]         data_byte,
    input  logic               packet_end,
    input  logic signed [63:0] base_ms,
    output hdr_time_t          hdr_time,
    output logic               res_valid,
    output result_t            res
);

    phase_t                   phase_reg;
    phase_t                   phase_next;
    logic [5:0]               byte_index_reg;
    logic [5:0]               byte_index_next;
    logic [15:0]              flows_left_reg;
    logic [15:0]              flows_left_next;
    logic                     drop_reg;
    logic                     drop_next;

    logic [HDR_BITS-1:0]      hdr_reg;
    logic [HDR_BITS-1:0]      hdr_cat;
    logic [REC_KEEP_BITS-1:0] rec_reg;
    logic [REC_BITS-1:0]      rec_cat;

    logic                     hdr_shift;
    logic                     rec_shift;
    logic                     emit;
    logic                     end_pkt;
    logic [15:0]              flows_dec;
    status_t                  rec_status;

    assign hdr_cat   = {hdr_reg[HDR_BITS-9:0], data_byte};
    assign rec_cat   = {rec_reg, data_byte};
    assign flows_dec = flows_left_reg - 16'd1;

    assign hdr_time.uptime = hdr_reg[159:128];
    assign hdr_time.secs   = hdr_reg[127:96];
    assign hdr_time.nsecs  = hdr_reg[95:64];

    always_comb
    begin
        phase_next      = phase_reg;
        byte_index_next = byte_index_reg;
        flows_left_next = flows_left_reg;
        drop_next       = drop_reg;
        hdr_shift       = 1'b0;
        rec_shift       = 1'b0;
        emit            = 1'b0;
        end_pkt         = 1'b0;
        rec_status      = ST_RECORD;
        res_valid       = 1'b0;
        res             = '0;

        if (drop_reg)
        begin
            end_pkt = packet_end;
        end
        else
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    hdr_shift = 1'b1;
                    if (byte_index_reg != HDR_LAST_IDX)
                    begin
                        byte_index_next = byte_index_reg + 6'd1;
                        if (packet_end)
                        begin
                            res_valid  = 1'b1;
                            res.status = ST_SHORT_HDR;
                            end_pkt    = 1'b1;
                        end
                    end
                    else if (hdr_cat[191:176] != NF_VERSION)
                    begin
                        res_valid       = 1'b1;
                        res.status      = ST_BAD_VERSION;
                        byte_index_next = 6'd0;
                        if (packet_end)
                        begin
                            end_pkt = 1'b1;
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                    end
                    else
                    begin
                        flows_left_next = hdr_cat[175:160];
                        byte_index_next = 6'd0;
                        if (hdr_cat[175:160] == 16'd0)
                        begin
                            if (packet_end)
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_END_OK;
                                end_pkt    = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_TRAILER;
                            end
                        end
                        else if (packet_end)
                        begin
                            res_valid  = 1'b1;
                            res.status = ST_TRUNCATED;
                            end_pkt    = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_RECORDS;
                        end
                    end
                end
                PH_RECORDS:
                begin
                    rec_shift = 1'b1;
                    if (byte_index_reg != REC_LAST_IDX)
                    begin
                        byte_index_next = byte_index_reg + 6'd1;
                        if (packet_end)
                        begin
                            res_valid  = 1'b1;
                            res.status = ST_TRUNCATED;
                            end_pkt    = 1'b1;
                        end
                    end
                    else
                    begin
                        byte_index_next = 6'd0;
                        flows_left_next = flows_dec;
                        if (flows_dec == 16'd0)
                        begin
                            emit = 1'b1;
                            if (packet_end)
                            begin
                                rec_status = ST_RECORD_END;
                                end_pkt    = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_TRAILER;
                            end
                        end
                        else if (packet_end)
                        begin
                            res_valid  = 1'b1;
                            res.status = ST_TRUNCATED;
                            end_pkt    = 1'b1;
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end
                end
                default:
                begin
                    if (packet_end)
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_END_OK;
                        end_pkt    = 1'b1;
                    end
                end
            endcase
        end

        if (end_pkt)
        begin
            phase_next      = PH_HEADER;
            byte_index_next = 6'd0;
            flows_left_next = 16'd0;
            drop_next       = 1'b0;
        end

        if (emit)
        begin
            res_valid        = 1'b1;
            res.status       = rec_status;
            res.first_ms     = base_ms + $signed({32'd0, rec_cat[191:160]});
            res.last_ms      = base_ms + $signed({32'd0, rec_cat[159:128]});
            res.addresses    = rec_cat[383:320];
            res.hop_addr     = rec_cat[319:288];
            res.interfaces   = rec_cat[287:256];
            res.packet_count = rec_cat[255:224];
            res.octet_count  = rec_cat[223:192];
            res.ports        = rec_cat[127:96];
            res.proto_info   = rec_cat[87:64];
            res.as_and_masks = rec_cat[63:16];
            res.header_info  = hdr_reg[63:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            byte_index_reg <= 6'd0;
            flows_left_reg <= 16'd0;
            drop_reg       <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            byte_index_reg <= byte_index_next;
            flows_left_reg <= flows_left_next;
            drop_reg       <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && hdr_shift)
        begin
            hdr_reg <= hdr_cat;
        end
        if (step_en && rec_shift)
        begin
            rec_reg <= rec_cat[REC_KEEP_BITS-1:0];
        end
    end

endmodule

FILE: tb/sv/netflow_v5_record_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NetFlow v5 record parser testbench
// Streams export packets into the decoder byte by byte: first a handful of
// hand-built corner packets, then randomly shaped well-formed and broken
// packets. A scoreboard mirrors the decoder's behaviour to predict every
// record and status, and compares each result field by field. Both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module netflow_v5_record_parser_tb;
    import nfv5_pkg::*;

    class flow_scoreboard;
        phase_t      phase;
        int unsigned byte_idx;
        logic [15:0] flows_left;
        logic [7:0]  hdr [HDR_BYTES];
        logic [7:0]  rec [REC_BYTES];
        logic [63:0] base_ms;
        bit          dropping;
        result_t     expected_q[$];
        int          errors;

        function new();
            foreach (hdr[i]) hdr[i] = 8'h00;
            foreach (rec[i]) rec[i] = 8'h00;
            base_ms   = 64'd0;
            errors    = 0;
            close_packet();
        endfunction

        function void close_packet();
            phase      = PH_HEADER;
            byte_idx   = 0;
            flows_left = 16'd0;
            dropping   = 1'b0;
        endfunction

        function logic [15:0] hdr16(int off);
            return {hdr[off], hdr[off + 1]};
        endfunction

        function logic [31:0] hdr32(int off);
            return {hdr16(off), hdr16(off + 2)};
        endfunction

        function logic [15:0] rec16(int off);
            return {rec[off], rec[off + 1]};
        endfunction

        function logic [31:0] rec32(int off);
            return {rec16(off), rec16(off + 2)};
        endfunction

        function void push_status(status_t st);
            result_t r;
            r = '0;
            r.status = st;
            expected_q.push_back(r);
        endfunction

        function void terminate(status_t st);
            push_status(st);
            close_packet();
        endfunction

        function void push_record(status_t st);
            result_t r;
            r = '0;
            r.status       = st;
            r.first_ms     = base_ms + 64'(rec32(24));
            r.last_ms      = base_ms + 64'(rec32(28));
            r.addresses    = {rec32(0), rec32(4)};
            r.hop_addr     = rec32(8);
            r.ports        = rec32(32);
            r.interfaces   = rec32(12);
            r.packet_count = rec32(16);
            r.octet_count  = rec32(20);
            r.proto_info   = {rec[37], rec[38], rec[39]};
            r.as_and_masks = {rec32(40), rec16(44)};
            r.header_info  = {hdr32(16), hdr32(20)};
            expected_q.push_back(r);
        endfunction

        function void note_input(logic [7:0] b, logic last);
            if (dropping)
            begin
                if (last)
                    close_packet();
                return;
            end
            if (phase == PH_HEADER)
            begin
                hdr[byte_idx] = b;
                byte_idx++;
                if (byte_idx < HDR_BYTES)
                begin
                    if (last)
                        terminate(ST_SHORT_HDR);
                    return;
                end
                if (hdr16(0) != NF_VERSION)
                begin
                    if (last)
                        terminate(ST_BAD_VERSION);
                    else
                    begin
                        push_status(ST_BAD_VERSION);
                        dropping = 1'b1;
                    end
                    return;
                end
                flows_left = hdr16(2);
                base_ms    = 64'(hdr32(8)) * 64'd1000 + 64'(hdr32(12) / 32'd1000000)
                           - 64'(hdr32(4));
                byte_idx   = 0;
                if (flows_left == 16'd0)
                begin
                    if (last)
                        terminate(ST_END_OK);
                    else
                        phase = PH_TRAILER;
                end
                else if (last)
                    terminate(ST_TRUNCATED);
                else
                    phase = PH_RECORDS;
                return;
            end
            if (phase == PH_RECORDS)
            begin
                rec[byte_idx] = b;
                byte_idx++;
                if (byte_idx < REC_BYTES)
                begin
                    if (last)
                        terminate(ST_TRUNCATED);
                    return;
                end
                byte_idx   = 0;
                flows_left = flows_left - 16'd1;
                if (flows_left == 16'd0)
                begin
                    if (last)
                    begin
                        push_record(ST_RECORD_END);
                        close_packet();
                    end
                    else
                    begin
                        push_record(ST_RECORD);
                        phase = PH_TRAILER;
                    end
                end
                else if (last)
                    terminate(ST_TRUNCATED);
                else
                    push_record(ST_RECORD);
                return;
            end
            if (last)
                terminate(ST_END_OK);
        endfunction

        function void diff(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $error("%s: expected %h, got %h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result with status %0d arrived with none outstanding", got.status);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            diff("status", want.status, got.status);
            diff("first_ms", want.first_ms, got.first_ms);
            diff("last_ms", want.last_ms, got.last_ms);
            diff("addresses", want.addresses, got.addresses);
            diff("hop_addr", want.hop_addr, got.hop_addr);
            diff("ports", want.ports, got.ports);
            diff("interfaces", want.interfaces, got.interfaces);
            diff("packet_count", want.packet_count, got.packet_count);
            diff("octet_count", want.octet_count, got.octet_count);
            diff("proto_info", want.proto_info, got.proto_info);
            diff("as_and_masks", want.as_and_masks, got.as_and_masks);
            diff("header_info", want.header_info, got.header_info);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         data_byte;
    logic               packet_end;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         status;
    logic signed [63:0] first_ms;
    logic signed [63:0] last_ms;
    logic [63:0]        addresses;
    logic [31:0]        hop_addr;
    logic [31:0]        ports;
    logic [31:0]        interfaces;
    logic [31:0]        packet_count;
    logic [31:0]        octet_count;
    logic [23:0]        proto_info;
    logic [47:0]        as_and_masks;
    logic [63:0]        header_info;

    flow_scoreboard sb;
    result_t        seen;
    logic [7:0]     pkt[$];
    bit             quiet_sender;
    int             sent_bytes;

    netflow_v5_record_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .packet_end   (packet_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .first_ms     (first_ms),
        .last_ms      (last_ms),
        .addresses    (addresses),
        .hop_addr     (hop_addr),
        .ports        (ports),
        .interfaces   (interfaces),
        .packet_count (packet_count),
        .octet_count  (octet_count),
        .proto_info   (proto_info),
        .as_and_masks (as_and_masks),
        .header_info  (header_info)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] pick32(int fill);
        int sel;
        if (fill == 1)
            return 32'h0000_0000;
        if (fill == 2)
            return 32'hFFFF_FFFF;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 32'h0000_0000;
        if (sel == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic int pick_gap();
        int sel;
        if (quiet_sender)
            return 0;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return 0;
        if (sel < 90)
            return $urandom_range(1, 2);
        if (sel < 97)
            return $urandom_range(3, 6);
        return $urandom_range(15, 40);
    endfunction

    task automatic push_be(logic [31:0] v, int n);
        for (int i = n - 1; i >= 0; i--)
            pkt.push_back(v[8 * i +: 8]);
    endtask

    task automatic make_header(logic [15:0] ver, logic [15:0] cnt, int fill);
        pkt.delete();
        push_be({ver, cnt}, 4);
        for (int i = 0; i < 5; i++)
            push_be(pick32(fill), 4);
    endtask

    task automatic add_records(int n, int fill);
        for (int i = 0; i < n * 12; i++)
            push_be(pick32(fill), 4);
    endtask

    task automatic add_random(int n);
        for (int i = 0; i < n; i++)
            pkt.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic cut_to(int len);
        while (pkt.size() > len)
            void'(pkt.pop_back());
    endtask

    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        data_byte  <= b;
        packet_end <= last;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(b, last);
        sent_bytes++;
    endtask

    task automatic send_packet();
        quiet_sender = ($urandom_range(0, 3) == 0);
        foreach (pkt[i])
            send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen.status       = status_t'(status);
            seen.first_ms     = first_ms;
            seen.last_ms      = last_ms;
            seen.addresses    = addresses;
            seen.hop_addr     = hop_addr;
            seen.ports        = ports;
            seen.interfaces   = interfaces;
            seen.packet_count = packet_count;
            seen.octet_count  = octet_count;
            seen.proto_info   = proto_info;
            seen.as_and_masks = as_and_masks;
            seen.header_info  = header_info;
            sb.check_result(seen);
        end
    end

    initial
    begin : stall_gen
        int run;
        int sel;
        run = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (run > 0)
                run--;
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 55)
                begin
                    out_stall <= 1'b0;
                    run = $urandom_range(0, 20);
                end
                else if (sel < 88)
                begin
                    out_stall <= 1'b1;
                    run = $urandom_range(0, 2);
                end
                else if (sel < 97)
                begin
                    out_stall <= 1'b1;
                    run = $urandom_range(3, 9);
                end
                else
                begin
                    out_stall <= 1'b1;
                    run = $urandom_range(20, 60);
                end
            end
        end
    end

    initial
    begin
        #(30_000_000);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int          kind;
        int          n;
        int          pkt_num;
        logic [15:0] ver;
        in_valid     = 1'b0;
        data_byte    = 8'h00;
        packet_end   = 1'b0;
        rst_n        = 1'b0;
        quiet_sender = 1'b0;
        sent_bytes   = 0;
        pkt_num      = 0;
        sb = new();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Hand-built corner packets.
        make_header(NF_VERSION, 16'd1, 0);
        cut_to(1);
        send_packet();
        make_header(NF_VERSION, 16'd1, 2);
        cut_to(HDR_BYTES - 1);
        send_packet();
        make_header(16'hFFFF, 16'd1, 2);
        send_packet();
        make_header(16'd4, 16'd2, 1);
        add_random(10);
        send_packet();
        make_header(NF_VERSION, 16'd0, 1);
        send_packet();
        make_header(NF_VERSION, 16'd0, 0);
        add_random(3);
        send_packet();
        make_header(NF_VERSION, 16'd1, 2);
        add_records(1, 2);
        send_packet();
        make_header(NF_VERSION, 16'd1, 1);
        add_records(1, 1);
        add_random(4);
        send_packet();
        make_header(NF_VERSION, 16'd3, 0);
        add_records(2, 0);
        send_packet();
        make_header(NF_VERSION, 16'd2, 0);
        add_records(2, 0);
        cut_to(HDR_BYTES + 26);
        send_packet();
        make_header(NF_VERSION, 16'hFFFF, 2);
        add_records(1, 0);
        add_random(10);
        send_packet();
        make_header(NF_VERSION, 16'd2, 0);
        add_records(2, 0);
        add_random(5);
        send_packet();
        drain();

        while (sent_bytes < 900)
        begin
            if (pkt_num == 6)
                drain();
            kind = $urandom_range(0, 99);
            if (kind < 65)
            begin
                n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
                make_header(NF_VERSION, 16'(n), 0);
                add_records(n, 0);
                if ($urandom_range(0, 3) == 0)
                    add_random($urandom_range(1, 6));
            end
            else if (kind < 77)
            begin
                n = $urandom_range(1, 3);
                make_header(NF_VERSION, 16'(n), 0);
                add_records(n, 0);
                if ($urandom_range(0, 2) == 0)
                    cut_to(HDR_BYTES + REC_BYTES * $urandom_range(0, n - 1));
                else
                    cut_to($urandom_range(HDR_BYTES + 1, HDR_BYTES + REC_BYTES * n - 1));
            end
            else if (kind < 85)
            begin
                ver = 16'($urandom);
                if (ver == NF_VERSION)
                    ver = ~ver;
                make_header(ver, 16'($urandom), 0);
                add_random($urandom_range(0, 20));
            end
            else if (kind < 91)
            begin
                make_header(NF_VERSION, 16'($urandom), 0);
                cut_to($urandom_range(1, HDR_BYTES - 1));
            end
            else if (kind < 95)
            begin
                make_header(NF_VERSION, 16'($urandom_range(4, 65535)), 0);
                add_records($urandom_range(0, 2), 0);
                add_random($urandom_range(1, REC_BYTES - 1));
            end
            else
            begin
                pkt.delete();
                add_random($urandom_range(1, 60));
            end
            send_packet();
            pkt_num++;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
